### sv/hgd_pkg.sv
// hgd_pkg: shared widths, constants, codes and types of the draw odds block
// no dependencies; used by hgd_mul, hgd_div and hypergeometric_draw_odds_core
`default_nettype none

package hgd_pkg;

    // operand and result widths
    localparam int ACC_W  = 64;                 // binomials and sums, below 2**61
    localparam int MB_W   = 16;                 // serial multiplier operand
    localparam int PROD_W = ACC_W + MB_W;       // product and dividend width
    localparam int CNT_W  = 7;                  // deck, copies and step counters
    localparam int DV_W   = 14;                 // recurrence divisor, up to 65 * 65
    localparam int ODDS_W = 14;

    localparam logic [ODDS_W-1:0] ODDS_MAX    = 14'd10000;
    // 2 * 10000, so that (2 * 10000 * num + den) / (2 * den) rounds half up
    localparam logic [MB_W-1:0]   ROUND_SCALE = 16'd20000;

    // configuration register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_TARGET = 2'd1;
    localparam logic [1:0] REG_HAND   = 2'd2;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // sequencer state
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_STEP  = 6'b000100,
        S_MUL   = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    // which quantity the sequencer is building
    typedef enum logic [4:0] {
        PH_DEN = 5'b00001,
        PH_TA  = 5'b00010,
        PH_TB  = 5'b00100,
        PH_REC = 5'b01000,
        PH_FIN = 5'b10000
    } phase_t;

endpackage

`default_nettype wire

### sv/hgd_mul.sv
// hgd_mul: bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on hgd_pkg
`default_nettype none

module hgd_mul
    import hgd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [ACC_W-1:0]  a,
    input  wire logic [MB_W-1:0]   b,
    output unit_stat_t             stat,
    output logic      [PROD_W-1:0] prod
);

    localparam int MC_W = $clog2(MB_W + 1);

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [ACC_W-1:0]  a_reg, a_next;
    logic [MB_W-1:0]   b_reg, b_next;
    logic [MC_W-1:0]   cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    // msb first: prod = 2 * prod + bit * a
    always_comb
    begin
        prod_next = prod_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            prod_next = '0;
            a_next    = a;
            b_next    = b;
            cnt_next  = MC_W'(MB_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = {prod_reg[PROD_W-2:0], 1'b0}
                      + (b_reg[MB_W-1] ? PROD_W'(a_reg) : '0);
            b_next    = {b_reg[MB_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == MC_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = prod_reg;

endmodule

`default_nettype wire

### sv/hgd_div.sv
// hgd_div: restoring divider, one quotient bit per cycle
// depends on hgd_pkg
`default_nettype none

module hgd_div
    import hgd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] dividend,
    input  wire logic [ACC_W-1:0]  divisor,
    output unit_stat_t             stat,
    output logic      [PROD_W-1:0] quotient
);

    localparam int DC_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [ACC_W-1:0]  rem_reg, rem_next;
    logic [ACC_W-1:0]  dsr_reg, dsr_next;
    logic [DC_W-1:0]   cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ACC_W:0]    trial;
    logic              fits;

    // shift the next dividend bit into the remainder and try the subtract
    assign trial = {rem_reg, quo_reg[PROD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = DC_W'(PROD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? ACC_W'(trial - {1'b0, dsr_reg}) : trial[ACC_W-1:0];
            quo_next = {quo_reg[PROD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DC_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

### sv/hypergeometric_draw_odds_core.sv
// channel  | signals                                          | direction
// item     | item_valid, item_stall, deck_total, matching_copies | in (stall out)
// result   | result_valid, result_stall, odds_hundredths      | out (stall in)
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data         | in (ready out)
//
// one item at a time; every arithmetic step is a serial multiply then
// a serial divide
// steps = 2 * hand_size + (top - first term) + 1
// rejected items give odds 0; reset restores mode 1, target 1, hand 7
// result register frees the datapath; item_stall is high while an item is in work
// depends on hgd_pkg, hgd_mul, hgd_div
`default_nettype none

module hypergeometric_draw_odds_core
    import hgd_pkg::*;
#(
    parameter int MAX_DECK = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire logic [6:0]        deck_total,
    input  wire logic [6:0]        matching_copies,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output logic      [ODDS_W-1:0] odds_hundredths,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [5:0]        cfg_data
);

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic               mode_reg;
    logic [5:0]         target_reg, hand_reg;
    logic [CNT_W-1:0]   deck_reg, deck_next, copies_reg, copies_next;
    logic [CNT_W-1:0]   lo_reg, lo_next, hi_reg, hi_next, k_reg, k_next;
    logic [CNT_W-1:0]   bin_a_reg, bin_a_next, bin_b_reg, bin_b_next;
    logic [CNT_W-1:0]   bin_i_reg, bin_i_next;
    logic [ACC_W-1:0]   acc_reg, acc_next, num_reg, num_next, den_reg, den_next;
    logic [MB_W-1:0]    mval_reg, mval_next;
    logic [DV_W-1:0]    dval_reg, dval_next;
    logic               mul_go_reg, mul_go_next, div_go_reg, div_go_next;
    logic [PROD_W-1:0]  div_nd_reg, div_nd_next;
    logic [ACC_W-1:0]   div_dsr_reg, div_dsr_next;
    logic [ODDS_W-1:0]  calc_reg, calc_next;
    logic [ODDS_W-1:0]  odds_reg, odds_next;
    logic               rv_reg, rv_next;

    unit_stat_t         mul_stat, div_stat;
    logic [PROD_W-1:0]  mul_prod, div_quo;

    logic [CNT_W-1:0]   hand7, target7, nk, floor_k, lo_c, cap, hi_c;
    logic               bad, bin_done;
    logic [2*CNT_W-1:0] rec_m, rec_d;
    logic [CNT_W-1:0]   k1, nk_gap;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b1;
            target_reg <= 6'd1;
            hand_reg   <= 6'd7;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[0];
                REG_TARGET: target_reg <= cfg_data;
                REG_HAND:   hand_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // range checks and term bounds
    assign hand7   = {1'b0, hand_reg};
    assign target7 = {1'b0, target_reg};
    assign nk      = deck_reg - copies_reg;
    assign bad     = (deck_reg > CNT_W'(MAX_DECK)) || (copies_reg > deck_reg)
                   || (hand7 > deck_reg) || (!mode_reg && (target7 > hand7));
    assign floor_k = (hand7 > nk) ? hand7 - nk : '0;
    assign lo_c    = (target7 > floor_k) ? target7 : floor_k;
    assign cap     = mode_reg ? hand7 : target7;
    assign hi_c    = (cap < copies_reg) ? cap : copies_reg;
    assign bin_done = bin_i_reg > bin_b_reg;

    // term ratio: t(k+1) = t(k) * (K-k)(n-k) / ((k+1)(N-K-n+k+1))
    assign k1     = k_reg + 1'b1;
    assign nk_gap = nk - hand7 + k1;
    assign rec_m  = (copies_reg - k_reg) * (hand7 - k_reg);
    assign rec_d  = k1 * nk_gap;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        deck_next    = deck_reg;
        copies_next  = copies_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        k_next       = k_reg;
        bin_a_next   = bin_a_reg;
        bin_b_next   = bin_b_reg;
        bin_i_next   = bin_i_reg;
        acc_next     = acc_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        mval_next    = mval_reg;
        dval_next    = dval_reg;
        mul_go_next  = 1'b0;
        div_go_next  = 1'b0;
        div_nd_next  = div_nd_reg;
        div_dsr_next = div_dsr_reg;
        calc_next    = calc_reg;
        odds_next    = odds_reg;
        rv_next      = rv_reg;
        if (rv_reg && !result_stall)
            rv_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    deck_next   = deck_total;
                    copies_next = matching_copies;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (bad || (lo_c > hi_c))
                begin
                    calc_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    lo_next    = lo_c;
                    hi_next    = hi_c;
                    phase_next = PH_DEN;
                    bin_a_next = deck_reg;
                    bin_b_next = hand7;
                    bin_i_next = CNT_W'(1);
                    acc_next   = ACC_W'(1);
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                // binomial step: c = c * (a - b + i) / i
                mval_next = MB_W'(bin_a_reg - bin_b_reg + bin_i_reg);
                dval_next = DV_W'(bin_i_reg);
                unique case (phase_reg)
                    PH_DEN:
                    begin
                        if (bin_done)
                        begin
                            den_next   = acc_reg;
                            acc_next   = ACC_W'(1);
                            bin_a_next = copies_reg;
                            bin_b_next = lo_reg;
                            bin_i_next = CNT_W'(1);
                            phase_next = PH_TA;
                        end
                        else
                        begin
                            mul_go_next = 1'b1;
                            state_next  = S_MUL;
                        end
                    end
                    PH_TA:
                    begin
                        if (bin_done)
                        begin
                            bin_a_next = nk;
                            bin_b_next = hand7 - lo_reg;
                            bin_i_next = CNT_W'(1);
                            phase_next = PH_TB;
                        end
                        else
                        begin
                            mul_go_next = 1'b1;
                            state_next  = S_MUL;
                        end
                    end
                    PH_TB:
                    begin
                        if (bin_done)
                        begin
                            num_next   = acc_reg;
                            k_next     = lo_reg;
                            phase_next = PH_REC;
                        end
                        else
                        begin
                            mul_go_next = 1'b1;
                            state_next  = S_MUL;
                        end
                    end
                    PH_REC:
                    begin
                        if (k_reg == hi_reg)
                        begin
                            phase_next = PH_FIN;
                            mval_next  = ROUND_SCALE;
                        end
                        else
                        begin
                            mval_next = MB_W'(rec_m);
                            dval_next = rec_d;
                        end
                        mul_go_next = 1'b1;
                        state_next  = S_MUL;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_MUL:
            begin
                if (mul_stat.done)
                begin
                    if (phase_reg == PH_FIN)
                    begin
                        div_nd_next  = mul_prod + PROD_W'(den_reg);
                        div_dsr_next = {den_reg[ACC_W-2:0], 1'b0};
                    end
                    else
                    begin
                        div_nd_next  = mul_prod;
                        div_dsr_next = ACC_W'(dval_reg);
                    end
                    div_go_next = 1'b1;
                    state_next  = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    if (phase_reg == PH_FIN)
                    begin
                        calc_next  = (div_quo > PROD_W'(ODDS_MAX)) ? ODDS_MAX
                                                                  : div_quo[ODDS_W-1:0];
                        state_next = S_OUT;
                    end
                    else if (phase_reg == PH_REC)
                    begin
                        acc_next   = div_quo[ACC_W-1:0];
                        num_next   = num_reg + div_quo[ACC_W-1:0];
                        k_next     = k1;
                        state_next = S_STEP;
                    end
                    else
                    begin
                        acc_next   = div_quo[ACC_W-1:0];
                        bin_i_next = bin_i_reg + 1'b1;
                        state_next = S_STEP;
                    end
                end
            end
            S_OUT:
            begin
                // the held result stays put until it is taken
                if (!rv_reg || !result_stall)
                begin
                    odds_next  = calc_reg;
                    rv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_DEN;
            rv_reg     <= 1'b0;
            mul_go_reg <= 1'b0;
            div_go_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            rv_reg     <= rv_next;
            mul_go_reg <= mul_go_next;
            div_go_reg <= div_go_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deck_reg    <= deck_next;
        copies_reg  <= copies_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        k_reg       <= k_next;
        bin_a_reg   <= bin_a_next;
        bin_b_reg   <= bin_b_next;
        bin_i_reg   <= bin_i_next;
        acc_reg     <= acc_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        mval_reg    <= mval_next;
        dval_reg    <= dval_next;
        div_nd_reg  <= div_nd_next;
        div_dsr_reg <= div_dsr_next;
        calc_reg    <= calc_next;
        odds_reg    <= odds_next;
    end

    // serial arithmetic units
    hgd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_go_reg),
        .a     ((phase_reg == PH_FIN) ? num_reg : acc_reg),
        .b     (mval_reg),
        .stat  (mul_stat),
        .prod  (mul_prod)
    );

    hgd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (div_nd_reg),
        .divisor  (div_dsr_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // ports
    assign item_stall      = (state_reg != S_IDLE);
    assign result_valid    = rv_reg;
    assign odds_hundredths = odds_reg;

    // checks
    a_odds_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> odds_hundredths <= ODDS_MAX)
        else $error("odds above full scale");

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_stat.busy && div_stat.busy))
        else $error("multiplier and divider busy together");

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> state_reg == S_CHECK)
        else $error("accepted item not checked");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (div_go_reg && phase_reg == PH_FIN) |-> den_reg != '0)
        else $error("final division by zero");

endmodule

`default_nettype wire
